// ===== src/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-512 stream hasher.
package sha_pkg;

   typedef logic [63:0] word_type;

   localparam int unsigned BlockWords  = 16;
   localparam int unsigned DigestWords = 8;
   localparam int unsigned RoundCount  = 80;

   localparam word_type IV [DigestWords] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam word_type K [RoundCount] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
      64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
      64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
      64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
      64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
      64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
      64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
      64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
      64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
      64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
      64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
      64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
      64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
      64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
      64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
      64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
      64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
      64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
      64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
      64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
      64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   function automatic word_type big_sigma0(input word_type x);
      return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
   endfunction

endpackage

// ===== src/sha512_stream_hasher_unit.sv =====
// SHA-512 stream hasher: word gathering, padding, round sequencer and digest output.
// A word that does not fill a block is only pushed; a word that fills one is pushed, then
// run through 80 rounds (one round per cycle on the shared round unit) and the hash update.
// The last word adds up to 17 padding pushes, one per cycle outside round runs, over two
// blocks at most, then 8 digest beats while rsp_tready is high; no new word before idle.
// Reset (synchronous, active high) loads the initial hash and clears counts.
module sha512_stream_hasher_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sha_pkg::word_type    req_tdata,   // [63:0] data_word
   input  logic [3:0]           req_tuser,   // [3:0] valid_bytes
   input  logic                 req_tlast,   // last_word
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output sha_pkg::word_type    rsp_tdata,   // [63:0] digest_word
   output logic [2:0]           rsp_tuser,   // [2:0] digest_index
   output logic                 rsp_tlast    // digest_last
);
   import sha_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROUND = 3'd1;
   localparam logic [2:0] S_FINAL = 3'd2;
   localparam logic [2:0] S_PAD   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   word_type    hash_ff [DigestWords];
   word_type    hash_in [DigestWords];
   word_type    work_ff [DigestWords];
   word_type    work_in [DigestWords];
   word_type    win_ff  [BlockWords];
   word_type    win_in  [BlockWords];
   logic [3:0]  fill_ff, fill_in;
   logic [60:0] bytes_ff, bytes_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [2:0]  idx_ff, idx_in;
   logic        pad_ff, pad_in;
   logic        pend_ff, pend_in;
   logic        lenok_ff, lenok_in;
   logic        done_ff, done_in;

   logic        push_en;
   word_type    push_data;
   logic [3:0]  vbe;
   word_type    keep_mask;
   word_type    t1, t2, sched;

   assign vbe       = (req_tuser > 4'd8 || !req_tlast) ? 4'd8 : req_tuser;
   assign keep_mask = ~(64'hffff_ffff_ffff_ffff >> {vbe, 3'b000});

   assign t1 = work_ff[7] + big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + K[rnd_ff] + win_ff[0];
   assign t2 = big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
               ^ (work_ff[1] & work_ff[2]));
   assign sched = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9]
                + small_sigma1(win_ff[14]);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = hash_ff[idx_ff];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      work_in  = work_ff;
      win_in   = win_ff;
      fill_in  = fill_ff;
      bytes_in = bytes_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      pad_in   = pad_ff;
      pend_in  = pend_ff;
      lenok_in = lenok_ff;
      done_in  = done_ff;
      push_en  = 1'b0;
      push_data = req_tdata;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               push_en  = 1'b1;
               bytes_in = bytes_ff + 61'(vbe);
               if (req_tlast) begin
                  pad_in = 1'b1;
                  if (vbe == 4'd8) begin
                     pend_in = 1'b1;
                  end else begin
                     push_data = (req_tdata & keep_mask)
                               | (64'h8000_0000_0000_0000 >> {vbe, 3'b000});
                     lenok_in  = (fill_ff <= 4'd13);
                  end
               end
            end
         end
         S_PAD: begin
            push_en = 1'b1;
            if (pend_ff) begin
               push_data = 64'h8000_0000_0000_0000;
               pend_in   = 1'b0;
               lenok_in  = (fill_ff <= 4'd13);
            end else if (lenok_ff && fill_ff == 4'd15) begin
               push_data = {bytes_ff, 3'b000};
               done_in   = 1'b1;
            end else begin
               push_data = '0;
            end
         end
         S_ROUND: begin
            for (int i = 0; i < int'(BlockWords) - 1; i++) win_in[i] = win_ff[i + 1];
            win_in[BlockWords - 1] = sched;
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'(RoundCount - 1)) state_in = S_FINAL;
         end
         S_FINAL: begin
            for (int i = 0; i < int'(DigestWords); i++) hash_in[i] = hash_ff[i] + work_ff[i];
            if (done_ff) begin
               state_in = S_OUT;
               idx_in   = '0;
            end else if (pad_ff) begin
               state_in = S_PAD;
               lenok_in = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  hash_in  = IV;
                  bytes_in = '0;
                  fill_in  = '0;
                  pad_in   = 1'b0;
                  done_in  = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // shift the beat into the block window; a full window starts the rounds
      if (push_en) begin
         for (int i = 0; i < int'(BlockWords) - 1; i++) win_in[i] = win_ff[i + 1];
         win_in[BlockWords - 1] = push_data;
         if (fill_ff == 4'd15) begin
            fill_in  = '0;
            rnd_in   = '0;
            work_in  = hash_ff;
            state_in = S_ROUND;
         end else begin
            fill_in  = fill_ff + 4'd1;
            state_in = pad_in ? S_PAD : S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      work_ff <= work_in;
      rnd_ff  <= rnd_in;
      idx_ff  <= idx_in;
      lenok_ff <= lenok_in;
      if (reset) begin
         state_ff <= S_IDLE;
         hash_ff  <= IV;
         fill_ff  <= '0;
         bytes_ff <= '0;
         pad_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         fill_ff  <= fill_in;
         bytes_ff <= bytes_in;
         pad_ff   <= pad_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while digest pending");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> (rnd_ff < 7'(RoundCount)))
      else $error("round counter out of range");
   a_out_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (done_ff && pad_ff && fill_ff == 4'd0))
      else $error("digest shown before final block");
   a_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && bytes_ff == '0))
      else $error("no return to idle after last digest beat");
`endif

endmodule
